// ===== rtl/core/psscd_pkg.sv =====
// shared constants and register map for the pot sample smoother
`default_nettype none

package psscd_pkg;

  // default ring depth
  localparam int unsigned FILTER_TAPS_DEF = 5;

  localparam int unsigned SAMPLE_W  = 12;
  localparam int unsigned PERCENT_W = 7;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 4;

  localparam logic [SAMPLE_W:0]    INVERT_BASE = 13'd4096;
  localparam logic [SAMPLE_W-1:0]  FULL_SCALE  = 12'd4095;
  localparam logic [PERCENT_W-1:0] PERCENT_MAX = 7'd100;

  // register reset values
  localparam logic [SAMPLE_W-1:0] LOW_CUTOFF_RST  = 12'd20;
  localparam logic [SAMPLE_W-1:0] HIGH_CUTOFF_RST = 12'd4050;
  localparam logic [SAMPLE_W-1:0] DELTA_THR_RST   = 12'd20;

  // register index, taken from paddr[3:2]
  typedef enum logic [1:0] {
    REG_LOW_CUTOFF  = 2'd0,
    REG_HIGH_CUTOFF = 2'd1,
    REG_DELTA_THR   = 2'd2
  } reg_idx_t;

  // floor(v * 100 / 4095) as (v * PCT_MULT) >> PCT_SHIFT, exact for 12-bit v
  localparam int unsigned PCT_SHIFT  = 32;
  localparam int unsigned PCT_MULT_W = 27;
  localparam int unsigned PCT_PROD_W = SAMPLE_W + PCT_MULT_W;
  localparam logic [PCT_MULT_W-1:0] PCT_MULT =
    PCT_MULT_W'(((64'd100 << PCT_SHIFT) + 64'd4094) / 64'd4095);

endpackage : psscd_pkg

`default_nettype wire

// ===== rtl/core/pot_sample_smoother_with_change_detect_top.sv =====
// pot sample smoother: invert and clamp, ring average, change detect, percent
//
// usage
//   in channel  : one raw 12-bit converter reading per transaction
//                 (in_valid / in_stall, taken when in_valid && !in_stall)
//   out channel : one result per input transaction, in order
//                 (out_changed, out_smoothed_value, out_level_percent)
//   apb port    : low_cutoff at 0x0, high_cutoff at 0x4, delta_threshold at 0x8,
//                 12-bit values in pwdata[11:0]; pready is tied high, reads return
//                 the register value; write only while the block is idle
// latency   : out_valid rises 3 cycles after the input transaction edge
// throughput: one transaction per cycle; the running-sum update and the
//             last-reported update are the only loops, each closes in one cycle
// reset     : synchronous, active low; ring entries, running sum, ring position
//             and last reported value go to zero, registers to 20 / 4050 / 20
// stall     : out_stall holds the output register; the pipeline keeps filling
//             empty stages, and in_stall rises only once stage one cannot drain
`default_nettype none

module pot_sample_smoother_with_change_detect_top
  import psscd_pkg::*;
#(
  parameter int unsigned FILTER_TAPS = FILTER_TAPS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // input channel
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [SAMPLE_W-1:0]    in_raw_sample,
  // result channel
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic                        out_changed,
  output logic [SAMPLE_W-1:0]         out_smoothed_value,
  output logic [PERCENT_W-1:0]        out_level_percent,
  // configuration
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [APB_ADDR_W-1:0]  paddr,
  input  wire logic [APB_DATA_W-1:0]  pwdata,
  output logic [APB_DATA_W-1:0]       prdata,
  output logic                        pready
);

  // ring pointer and running sum widths follow the tap count
  localparam int unsigned PW = (FILTER_TAPS > 1) ? $clog2(FILTER_TAPS) : 1;
  localparam int unsigned SW = $clog2(FILTER_TAPS * 4095 + 1);
  localparam logic [PW-1:0] POS_LAST = PW'(FILTER_TAPS - 1);

  // mean = sum / FILTER_TAPS done as multiply by rounded-up reciprocal;
  // the extra shift bits keep the result exact over the whole sum range
  localparam int unsigned MEAN_SHIFT = SW + 5;
  localparam int unsigned MW         = MEAN_SHIFT + 1;
  localparam int unsigned MPW        = SW + MW;
  localparam logic [MW-1:0] MEAN_MULT =
    MW'(((64'd1 << MEAN_SHIFT) + 64'(FILTER_TAPS) - 64'd1) / 64'(FILTER_TAPS));

  //--------------------------------------------------------------------------
  // configuration registers
  //--------------------------------------------------------------------------
  logic [SAMPLE_W-1:0] low_cutoff_r;
  logic [SAMPLE_W-1:0] high_cutoff_r;
  logic [SAMPLE_W-1:0] delta_thr_r;
  logic                cfg_wr;
  reg_idx_t            cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_cutoff_r  <= LOW_CUTOFF_RST;
      high_cutoff_r <= HIGH_CUTOFF_RST;
      delta_thr_r   <= DELTA_THR_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_LOW_CUTOFF:  low_cutoff_r  <= pwdata[SAMPLE_W-1:0];
        REG_HIGH_CUTOFF: high_cutoff_r <= pwdata[SAMPLE_W-1:0];
        REG_DELTA_THR:   delta_thr_r   <= pwdata[SAMPLE_W-1:0];
        default: ;  // unmapped address, write dropped
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_LOW_CUTOFF:  prdata = APB_DATA_W'(low_cutoff_r);
      REG_HIGH_CUTOFF: prdata = APB_DATA_W'(high_cutoff_r);
      REG_DELTA_THR:   prdata = APB_DATA_W'(delta_thr_r);
      default:         prdata = '0;
    endcase
  end

  //--------------------------------------------------------------------------
  // pipeline flow control: a stage loads when it is empty or draining
  //--------------------------------------------------------------------------
  logic s1_valid_r, s2_valid_r, s3_valid_r;
  logic rdy1, rdy2, rdy3, rdy4;
  logic in_take;

  assign rdy4     = !out_valid || !out_stall;
  assign rdy3     = !s3_valid_r || rdy4;
  assign rdy2     = !s2_valid_r || rdy3;
  assign rdy1     = !s1_valid_r || rdy2;
  assign in_stall = !rdy1;
  assign in_take  = in_valid && rdy1;

  //--------------------------------------------------------------------------
  // stage 0 -> 1: condition sample, write ring, update running sum
  //--------------------------------------------------------------------------
  logic [SAMPLE_W-1:0] ring_r [FILTER_TAPS];
  logic [PW-1:0]       ring_pos_r;
  logic [PW-1:0]       ring_pos_nxt;
  logic [SW-1:0]       run_sum_r;
  logic [SW-1:0]       run_sum_nxt;
  logic [SAMPLE_W:0]   inverted;
  logic [SAMPLE_W-1:0] cond_sample;
  logic [SW-1:0]       s1_sum_r;

  always_comb begin
    // inversion spans 1..4096, so 13 bits
    inverted = INVERT_BASE - {1'b0, in_raw_sample};
    if (inverted < {1'b0, low_cutoff_r}) begin
      inverted = '0;
    end
    // low test first; a zeroed value never passes the high test
    if (inverted > {1'b0, high_cutoff_r}) begin
      cond_sample = FULL_SCALE;
    end else begin
      cond_sample = inverted[SAMPLE_W-1:0];
    end
    run_sum_nxt  = run_sum_r - SW'(ring_r[ring_pos_r]) + SW'(cond_sample);
    ring_pos_nxt = (ring_pos_r == POS_LAST) ? '0 : ring_pos_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < FILTER_TAPS; i++) begin
        ring_r[i] <= '0;
      end
      ring_pos_r <= '0;
      run_sum_r  <= '0;
    end else if (in_take) begin
      ring_r[ring_pos_r] <= cond_sample;
      ring_pos_r         <= ring_pos_nxt;
      run_sum_r          <= run_sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (rdy1) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_sum_r <= run_sum_nxt;
    end
  end

  //--------------------------------------------------------------------------
  // stage 1 -> 2: mean by reciprocal multiply
  //--------------------------------------------------------------------------
  logic [MPW-1:0]      mean_prod;
  logic [SAMPLE_W-1:0] mean_val;
  logic [SAMPLE_W-1:0] s2_mean_r;

  assign mean_prod = MPW'(s1_sum_r) * MPW'(MEAN_MULT);
  assign mean_val  = mean_prod[MEAN_SHIFT +: SAMPLE_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (rdy2) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && s1_valid_r) begin
      s2_mean_r <= mean_val;
    end
  end

  //--------------------------------------------------------------------------
  // stage 2 -> 3: deadband compare against last reported value
  //--------------------------------------------------------------------------
  logic [SAMPLE_W-1:0] last_rep_r;
  logic [SAMPLE_W-1:0] last_rep_nxt;
  logic [SAMPLE_W-1:0] mean_diff;
  logic                moved;
  logic                s2_move;
  logic                s3_changed_r;
  logic [SAMPLE_W-1:0] s3_mean_r;
  logic [SAMPLE_W-1:0] s3_rep_r;

  assign s2_move = s2_valid_r && rdy3;

  always_comb begin
    mean_diff    = (s2_mean_r >= last_rep_r) ? (s2_mean_r - last_rep_r)
                                             : (last_rep_r - s2_mean_r);
    moved        = mean_diff > delta_thr_r;
    last_rep_nxt = moved ? s2_mean_r : last_rep_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_rep_r <= '0;
      s3_valid_r <= 1'b0;
    end else begin
      if (s2_move) begin
        last_rep_r <= last_rep_nxt;
      end
      if (rdy3) begin
        s3_valid_r <= s2_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_move) begin
      s3_changed_r <= moved;
      s3_mean_r    <= s2_mean_r;
      s3_rep_r     <= last_rep_nxt;
    end
  end

  //--------------------------------------------------------------------------
  // stage 3 -> output: percent of reported value
  //--------------------------------------------------------------------------
  logic [PCT_PROD_W-1:0] pct_prod;
  logic                  out_valid_r;
  logic                  out_changed_r;
  logic [SAMPLE_W-1:0]   out_smoothed_r;
  logic [PERCENT_W-1:0]  out_percent_r;

  assign pct_prod = PCT_PROD_W'(s3_rep_r) * PCT_PROD_W'(PCT_MULT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rdy4) begin
      out_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && s3_valid_r) begin
      out_changed_r  <= s3_changed_r;
      out_smoothed_r <= s3_mean_r;
      out_percent_r  <= pct_prod[PCT_SHIFT +: PERCENT_W];
    end
  end

  assign out_valid          = out_valid_r;
  assign out_changed        = out_changed_r;
  assign out_smoothed_value = out_smoothed_r;
  assign out_level_percent  = out_percent_r;

  //--------------------------------------------------------------------------
  // assertions
  //--------------------------------------------------------------------------
  // input side only backs up when stage one is holding an item
  a_stall_needs_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("in_stall raised with stage one empty");

  // reported value moves only when an item passes the deadband stage
  a_rep_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !s2_move |=> $stable(last_rep_r))
    else $error("last reported value changed without an item");

  // a changed result carries its own mean as the reported value
  a_changed_rep: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_valid_r && s3_changed_r) |-> (s3_rep_r == s3_mean_r))
    else $error("changed item does not report its mean");

  // ring pointer never leaves the ring
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    ring_pos_r <= POS_LAST)
    else $error("ring position out of range");

  // percent stays within 0..100
  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_percent_r <= PERCENT_MAX))
    else $error("level percent above 100");

endmodule : pot_sample_smoother_with_change_detect_top

`default_nettype wire
